FILE: rtl/ids_pkg.sv
// Shared types and constants for the image difference and similarity core.
`timescale 1ns / 1ps

package ids_pkg;

  localparam int PIX_W   = 8;
  localparam int TOTAL_W = 23;
  localparam int SHARE_W = 14;
  localparam int SCALE_W = 15;

  localparam logic [PIX_W-1:0]   CHAN_MAX = 8'd255;
  // Twice the hundredths-of-a-percent scale, for half-up rounding.
  localparam logic [SCALE_W-1:0] SCALE2   = 15'd20000;
  // 255 cubed, the largest per-pixel similarity product.
  localparam logic [3*PIX_W-1:0] CUBE     = 24'd16581375;

  typedef struct packed {
    logic [PIX_W-1:0] first_red;
    logic [PIX_W-1:0] first_green;
    logic [PIX_W-1:0] first_blue;
    logic [PIX_W-1:0] second_red;
    logic [PIX_W-1:0] second_green;
    logic [PIX_W-1:0] second_blue;
    logic             final_pixel;
  } ids_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   diff_red;
    logic [PIX_W-1:0]   diff_green;
    logic [PIX_W-1:0]   diff_blue;
    logic               stats_valid;
    logic [TOTAL_W-1:0] identical_total;
    logic [TOTAL_W-1:0] pixel_total;
    logic [SHARE_W-1:0] identical_share;
    logic [SHARE_W-1:0] similarity_share;
  } ids_out_t;

  typedef struct packed {
    logic take_pixel;
    logic load_diff;
    logic take_final;
    logic step_mul1;
    logic step_mul2;
    logic step_addn;
    logic div_start;
    logic div_sel;
    logic store_ishare;
    logic store_sshare;
    logic emit;
  } ids_cmd_t;

  typedef struct packed {
    logic div_done;
  } ids_stat_t;

endpackage

FILE: rtl/ids_div.sv
// Iterative restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module ids_div #(
  parameter int NUM_W = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num,
  input  logic [NUM_W-1:0]            den,
  output logic [ids_pkg::SHARE_W-1:0] quot,
  output logic                        done
);

  localparam int QW    = ids_pkg::SHARE_W;
  localparam int CNT_W = $clog2(QW);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [QW-1:0]    q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  // The quotient is known to stay below 2^QW, so the divisor starts
  // aligned QW-1 places up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= den << (QW - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

FILE: rtl/ids_datapath.sv
// Datapath: difference pixels, accumulators, share arithmetic and result register.
`timescale 1ns / 1ps

module ids_datapath #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ids_pkg::ids_in_t   in_item,
  input  ids_pkg::ids_cmd_t  cmd,
  output ids_pkg::ids_stat_t stat,
  output ids_pkg::ids_out_t  out_item
);

  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int CH_W   = ids_pkg::PIX_W;
  localparam int IA_W   = 2 * CH_W;
  localparam int PROD_W = 3 * CH_W;
  localparam int SC_W   = ids_pkg::SCALE_W;
  localparam int SUM_W  = CNT_W + PROD_W;
  localparam int NUM_W  = SUM_W + SC_W;
  localparam int LO_W   = PROD_W + SC_W;
  localparam int PCC_W  = CNT_W + PROD_W;
  localparam int IN_W   = CNT_W + SC_W;
  localparam int SH_W   = ids_pkg::SHARE_W;
  localparam int TOT_W  = ids_pkg::TOTAL_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [CH_W-1:0] dr, dg, db;
  logic [CH_W-1:0] inv_r, inv_g, inv_b;
  logic            identical;
  logic            below_max;

  logic [IA_W-1:0]   ia_r;
  logic [CH_W-1:0]   cb_r;
  logic              p1_v_r;
  logic [PROD_W-1:0] prod_r;
  logic              p2_v_r;

  logic [CNT_W-1:0] pc_r;
  logic [CNT_W-1:0] ic_r;
  logic [SUM_W-1:0] sum_r;

  logic [3*CH_W-1:0] hold_r;

  logic [LO_W-1:0]    plo_r;
  logic [PCC_W-1:0]   pcc_r;
  logic [IN_W-1:0]    ipr_r;
  logic [IN_W-1:0]    ni_r;
  logic [IN_W-1:0]    phi_r;
  logic [NUM_W-1:0]   acc_r;
  logic [NUM_W-1:0]   ns_r;
  logic [PCC_W:0]     ds_r;
  logic [CNT_W:0]     di;

  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_den;
  logic [SH_W-1:0]  quot;
  logic             div_done;
  logic             pc_zero;

  logic [SH_W-1:0] ishare_r;
  logic [SH_W-1:0] sshare_r;

  ids_pkg::ids_out_t out_r;

  always_comb begin
    dr = (in_item.second_red > in_item.first_red) ?
         in_item.second_red - in_item.first_red : in_item.first_red - in_item.second_red;
    dg = (in_item.second_green > in_item.first_green) ?
         in_item.second_green - in_item.first_green :
         in_item.first_green - in_item.second_green;
    db = (in_item.second_blue > in_item.first_blue) ?
         in_item.second_blue - in_item.first_blue : in_item.first_blue - in_item.second_blue;
    inv_r     = ids_pkg::CHAN_MAX - dr;
    inv_g     = ids_pkg::CHAN_MAX - dg;
    inv_b     = ids_pkg::CHAN_MAX - db;
    identical = (dr == '0) && (dg == '0) && (db == '0);
    below_max = (pc_r < CNT_MAX);
  end

  // Similarity product pipeline: two multiplies, then the accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.take_pixel && below_max;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      ia_r <= IA_W'(inv_r) * IA_W'(inv_g);
      cb_r <= inv_b;
    end
    prod_r <= PROD_W'(ia_r) * PROD_W'(cb_r);
  end

  // Pixels past the limit still get a difference but are not counted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      ic_r  <= '0;
      sum_r <= '0;
    end else if (cmd.emit) begin
      pc_r  <= '0;
      ic_r  <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.take_pixel && below_max) begin
        pc_r <= pc_r + CNT_W'(1);
        ic_r <= ic_r + CNT_W'(identical);
      end
      if (p2_v_r) begin
        sum_r <= sum_r + SUM_W'(prod_r);
      end
    end
  end

  // Shares: identical = (ic*20000 + pc) / (2*pc),
  // similarity = (sum*20000 + pc*C) / (2*pc*C), with C = 255^3.
  always_ff @(posedge clk) begin
    if (cmd.take_final) begin
      hold_r <= {dr, dg, db};
    end
    if (cmd.step_mul1) begin
      plo_r <= LO_W'(sum_r[PROD_W-1:0]) * LO_W'(ids_pkg::SCALE2);
      pcc_r <= PCC_W'(pc_r) * PCC_W'(ids_pkg::CUBE);
      ipr_r <= IN_W'(ic_r) * IN_W'(ids_pkg::SCALE2);
    end
    if (cmd.step_mul2) begin
      ni_r  <= ipr_r + IN_W'(pc_r);
      phi_r <= IN_W'(sum_r[SUM_W-1:PROD_W]) * IN_W'(ids_pkg::SCALE2);
      acc_r <= NUM_W'(plo_r) + NUM_W'(pcc_r);
    end
    if (cmd.step_addn) begin
      ns_r <= (NUM_W'(phi_r) << PROD_W) + acc_r;
      ds_r <= {pcc_r, 1'b0};
    end
    if (cmd.store_ishare) begin
      ishare_r <= pc_zero ? '0 : quot;
    end
    if (cmd.store_sshare) begin
      sshare_r <= pc_zero ? '0 : quot;
    end
  end

  assign di      = {pc_r, 1'b0};
  assign pc_zero = (pc_r == '0);
  assign div_num = cmd.div_sel ? ns_r : NUM_W'(ni_r);
  assign div_den = cmd.div_sel ? NUM_W'(ds_r) : NUM_W'(di);

  ids_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      out_r.diff_red         <= dr;
      out_r.diff_green       <= dg;
      out_r.diff_blue        <= db;
      out_r.stats_valid      <= 1'b0;
      out_r.identical_total  <= '0;
      out_r.pixel_total      <= '0;
      out_r.identical_share  <= '0;
      out_r.similarity_share <= '0;
    end else if (cmd.emit) begin
      out_r.diff_red         <= hold_r[3*CH_W-1:2*CH_W];
      out_r.diff_green       <= hold_r[2*CH_W-1:CH_W];
      out_r.diff_blue        <= hold_r[CH_W-1:0];
      out_r.stats_valid      <= 1'b1;
      out_r.identical_total  <= TOT_W'(ic_r);
      out_r.pixel_total      <= TOT_W'(pc_r);
      out_r.identical_share  <= ishare_r;
      out_r.similarity_share <= sshare_r;
    end
  end

  assign stat.div_done = div_done;
  assign out_item      = out_r;

endmodule

FILE: rtl/ids_ctrl.sv
// Controller: handshakes and the sequence that closes out an image.
`timescale 1ns / 1ps

module ids_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_final,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output ids_pkg::ids_cmd_t  cmd,
  input  ids_pkg::ids_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAIN1,
    S_DRAIN2,
    S_MUL1,
    S_MUL2,
    S_ADDN,
    S_DIV_I_GO,
    S_DIV_I_WAIT,
    S_DIV_S_GO,
    S_DIV_S_WAIT,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.div_sel  = (state_r == S_DIV_S_GO) || (state_r == S_DIV_S_WAIT);
    unique case (state_r)
      S_IDLE: begin
        cmd.take_pixel = accept;
        cmd.load_diff  = accept && !in_final;
        cmd.take_final = accept && in_final;
        if (accept && in_final) begin
          state_nxt = S_DRAIN1;
        end
      end
      // The drain states let the last product pass through prod_r into the similarity sum.
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_MUL1;
      S_MUL1: begin
        cmd.step_mul1 = 1'b1;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        cmd.step_mul2 = 1'b1;
        state_nxt     = S_ADDN;
      end
      S_ADDN: begin
        cmd.step_addn = 1'b1;
        state_nxt     = S_DIV_I_GO;
      end
      S_DIV_I_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_I_WAIT;
      end
      S_DIV_I_WAIT: begin
        if (stat.div_done) begin
          cmd.store_ishare = 1'b1;
          state_nxt        = S_DIV_S_GO;
        end
      end
      S_DIV_S_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_S_WAIT;
      end
      S_DIV_S_WAIT: begin
        if (stat.div_done) begin
          cmd.store_sshare = 1'b1;
          state_nxt        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_diff || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/image_difference_similarity_core.sv
// Top level of the image difference and similarity core.
`timescale 1ns / 1ps

// Each item is one RGB pixel pair; each result is the per-channel absolute
// difference. Ordinary pixels are taken one per cycle unless the output stalls,
// with the result held in an output register so a new item enters in the cycle
// that the previous result is taken. The item flagged final_pixel also carries
// the pixel count, the count of identical pixels and two shares in hundredths
// of a percent; that item holds off input until its result is loaded, through
// the product pipeline drain, three multiply and add steps, and two passes of a
// shared one-bit-per-cycle divider. Counting stops at MAX_PIXELS.

module image_difference_similarity_core #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ids_pkg::ids_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ids_pkg::ids_out_t out_item
);

  ids_pkg::ids_cmd_t  cmd;
  ids_pkg::ids_stat_t stat;

  ids_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_item.final_pixel),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  ids_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
